/* hdl/llnc_pkg.sv */
// ----------------------------------------------------------------------------
// llnc_pkg
// Shared constants, types and helpers for the least-loaded node chooser.
// ----------------------------------------------------------------------------
package llnc_pkg;

  localparam int MAX_NODES = 16;
  localparam int NUM_TYPES = 16;
  localparam int NODE_IW   = $clog2(MAX_NODES);
  localparam int TYPE_IW   = $clog2(NUM_TYPES);

  localparam int CMD_W  = 2;
  localparam int ID_W   = 16;
  localparam int TYPE_W = 4;
  localparam int WGT_W  = 16;
  localparam int LOAD_W = 32;
  localparam int STAT_W = 2;

  localparam int IN_DATA_W  = 72;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_USER_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_CHOOSE = 2'd1,
    CMD_WRITE  = 2'd2,
    CMD_NONE   = 2'd3
  } llnc_op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_DUP   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } llnc_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } llnc_state_e;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } llnc_cmd_t;

  typedef struct packed {
    logic scan_last;
  } llnc_sts_t;

  typedef struct packed {
    llnc_op_e          op;
    logic [ID_W-1:0]   node_id;
    logic [TYPE_W-1:0] node_type;
    logic [ID_W-1:0]   force_node;
    logic [WGT_W-1:0]  bandwidth_weight;
    logic [WGT_W-1:0]  overload_weight;
  } llnc_req_t;

  typedef struct packed {
    llnc_status_e    status;
    logic            found;
    logic [ID_W-1:0] chosen_node;
  } llnc_res_t;

  function automatic logic [LOAD_W-1:0] sat_add(input logic [LOAD_W-1:0] a,
                                                input logic [WGT_W-1:0]  w);
    logic [LOAD_W:0] s;
    s = {1'b0, a} + (LOAD_W+1)'(w);
    return s[LOAD_W] ? {LOAD_W{1'b1}} : s[LOAD_W-1:0];
  endfunction

endpackage

/* hdl/llnc_ctrl.sv */
// ----------------------------------------------------------------------------
// llnc_ctrl
// Request sequencer: accept, table scan, commit, output register handshake.
// ----------------------------------------------------------------------------
module llnc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  input  llnc_pkg::llnc_sts_t sts_i,
  output llnc_pkg::llnc_cmd_t cmd_o
);

  llnc_pkg::llnc_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= llnc_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !m_ready_i;
    cmd_o       = '0;
    s_ready_o   = 1'b0;
    case (state_q)
      llnc_pkg::S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = llnc_pkg::S_SCAN;
        end
      end
      llnc_pkg::S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = llnc_pkg::S_COMMIT;
        end
      end
      llnc_pkg::S_COMMIT: begin
        if (!out_valid_q || m_ready_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = llnc_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = llnc_pkg::S_IDLE;
      end
    endcase
  end

  assign m_valid_o = out_valid_q;

  a_load_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == llnc_pkg::S_SCAN)
    else $error("request accepted without starting a scan");

  a_commit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> m_valid_o && state_q == llnc_pkg::S_IDLE)
    else $error("commit did not present a result");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_o && !m_ready_i) |=> m_valid_o)
    else $error("result dropped before it was taken");

endmodule

/* hdl/llnc_dp.sv */
// ----------------------------------------------------------------------------
// llnc_dp
// Node and type tables, scan accumulators, update logic and result register.
// ----------------------------------------------------------------------------
module llnc_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  llnc_pkg::llnc_cmd_t         cmd_i,
  output llnc_pkg::llnc_sts_t         sts_o,
  input  llnc_pkg::llnc_req_t         req_i,
  input  logic                        cfg_we_i,
  input  logic [llnc_pkg::TYPE_W-1:0] cfg_wdata_i,
  output llnc_pkg::llnc_res_t         res_o
);

  localparam int NODE_IW = llnc_pkg::NODE_IW;
  localparam int TYPE_IW = llnc_pkg::TYPE_IW;
  localparam int ID_W    = llnc_pkg::ID_W;
  localparam int LOAD_W  = llnc_pkg::LOAD_W;
  localparam int WGT_W   = llnc_pkg::WGT_W;
  localparam int TYPE_W  = llnc_pkg::TYPE_W;

  // configuration
  logic [TYPE_W-1:0] gate_q;

  // node table
  logic [llnc_pkg::MAX_NODES-1:0] node_valid_q;
  logic [ID_W-1:0]   node_ident_q [llnc_pkg::MAX_NODES];
  logic [LOAD_W-1:0] node_bw_q    [llnc_pkg::MAX_NODES];
  logic [LOAD_W-1:0] node_ov_q    [llnc_pkg::MAX_NODES];

  // per-type table
  logic [ID_W-1:0]  type_force_q [llnc_pkg::NUM_TYPES];
  logic [WGT_W-1:0] type_bw_q    [llnc_pkg::NUM_TYPES];
  logic [WGT_W-1:0] type_ov_q    [llnc_pkg::NUM_TYPES];

  // latched request
  llnc_pkg::llnc_req_t req_q;
  logic [ID_W-1:0]     force_q;
  logic [WGT_W-1:0]    wb_q, wo_q;

  // scan state
  logic [NODE_IW-1:0] cnt_q;
  logic               any_q;
  logic               match_hit_q, free_hit_q, best_hit_q;
  logic [NODE_IW-1:0] match_idx_q, free_idx_q, best_idx_q;
  logic [LOAD_W-1:0]  match_bw_q, match_ov_q, best_bw_q, best_ov_q;
  logic [ID_W-1:0]    best_id_q;

  llnc_pkg::llnc_res_t res_q, res_d;

  logic               in_type_ok, cur_type_ok;
  logic [TYPE_IW-1:0] in_tidx, cur_tidx;
  logic               e_v;
  logic [ID_W-1:0]    e_id, key;
  logic [LOAD_W-1:0]  e_bw, e_ov, k1, k2, bk1, bk2;
  logic               gate, better, match_now;

  logic               wr_en, tw_en;
  logic [NODE_IW-1:0] wr_idx;
  logic [ID_W-1:0]    wr_id;
  logic [LOAD_W-1:0]  wr_bw, wr_ov;

  assign in_tidx     = TYPE_IW'(req_i.node_type);
  assign cur_tidx    = TYPE_IW'(req_q.node_type);
  assign in_type_ok  = 32'(req_i.node_type) < 32'(llnc_pkg::NUM_TYPES);
  assign cur_type_ok = 32'(req_q.node_type) < 32'(llnc_pkg::NUM_TYPES);

  assign sts_o.scan_last = cnt_q == NODE_IW'(llnc_pkg::MAX_NODES - 1);

  // entry under scan
  assign e_v  = node_valid_q[cnt_q];
  assign e_id = node_ident_q[cnt_q];
  assign e_bw = node_bw_q[cnt_q];
  assign e_ov = node_ov_q[cnt_q];

  assign key       = (req_q.op == llnc_pkg::CMD_ADD) ? req_q.node_id : force_q;
  assign match_now = e_v && (e_id == key);

  assign gate = req_q.node_type == gate_q;
  assign k1   = gate ? e_bw : e_ov;
  assign k2   = gate ? e_ov : e_bw;
  assign bk1  = gate ? best_bw_q : best_ov_q;
  assign bk2  = gate ? best_ov_q : best_bw_q;
  assign better = !best_hit_q || (k1 < bk1) ||
                  ((k1 == bk1) && ((k2 < bk2) || ((k2 == bk2) && (e_id < best_id_q))));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_q <= '0;
    end else if (cfg_we_i) begin
      gate_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q   <= req_i;
      force_q <= in_type_ok ? type_force_q[in_tidx] : '0;
      wb_q    <= in_type_ok ? type_bw_q[in_tidx] : '0;
      wo_q    <= in_type_ok ? type_ov_q[in_tidx] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      any_q       <= 1'b0;
      match_hit_q <= 1'b0;
      free_hit_q  <= 1'b0;
      best_hit_q  <= 1'b0;
    end else if (cmd_i.load) begin
      cnt_q       <= '0;
      any_q       <= 1'b0;
      match_hit_q <= 1'b0;
      free_hit_q  <= 1'b0;
      best_hit_q  <= 1'b0;
    end else if (cmd_i.scan) begin
      cnt_q <= cnt_q + NODE_IW'(1);
      if (e_v) begin
        any_q <= 1'b1;
      end
      if (match_now) begin
        match_hit_q <= 1'b1;
      end
      if (!e_v) begin
        free_hit_q <= 1'b1;
      end
      if (e_v && better) begin
        best_hit_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      if (match_now && !match_hit_q) begin
        match_idx_q <= cnt_q;
        match_bw_q  <= e_bw;
        match_ov_q  <= e_ov;
      end
      if (!e_v && !free_hit_q) begin
        free_idx_q <= cnt_q;
      end
      if (e_v && better) begin
        best_idx_q <= cnt_q;
        best_bw_q  <= e_bw;
        best_ov_q  <= e_ov;
        best_id_q  <= e_id;
      end
    end
  end

  // commit decision
  always_comb begin
    res_d       = '{status: llnc_pkg::ST_OK, found: 1'b0, chosen_node: '0};
    wr_en       = 1'b0;
    tw_en       = 1'b0;
    wr_idx      = match_idx_q;
    wr_id       = force_q;
    wr_bw       = llnc_pkg::sat_add(match_bw_q, wb_q);
    wr_ov       = llnc_pkg::sat_add(match_ov_q, wo_q);
    case (req_q.op)
      llnc_pkg::CMD_ADD: begin
        if (match_hit_q) begin
          res_d.status = llnc_pkg::ST_DUP;
        end else if (free_hit_q) begin
          wr_en  = 1'b1;
          wr_idx = free_idx_q;
          wr_id  = req_q.node_id;
          wr_bw  = '0;
          wr_ov  = '0;
        end else begin
          res_d.status = llnc_pkg::ST_FULL;
        end
      end
      llnc_pkg::CMD_WRITE: begin
        tw_en = cur_type_ok;
      end
      llnc_pkg::CMD_CHOOSE: begin
        if (!any_q) begin
          res_d.status = llnc_pkg::ST_EMPTY;
        end else if (force_q != '0) begin
          res_d.found       = 1'b1;
          res_d.chosen_node = force_q;
          if (match_hit_q) begin
            wr_en = 1'b1;
          end else if (free_hit_q) begin
            wr_en  = 1'b1;
            wr_idx = free_idx_q;
            wr_bw  = LOAD_W'(wb_q);
            wr_ov  = LOAD_W'(wo_q);
          end else begin
            res_d.status = llnc_pkg::ST_FULL;
          end
        end else if (best_hit_q && best_id_q != '0) begin
          res_d.found       = 1'b1;
          res_d.chosen_node = best_id_q;
          wr_en  = 1'b1;
          wr_idx = best_idx_q;
          wr_id  = best_id_q;
          wr_bw  = llnc_pkg::sat_add(best_bw_q, wb_q);
          wr_ov  = llnc_pkg::sat_add(best_ov_q, wo_q);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_valid_q <= '0;
    end else if (cmd_i.commit && wr_en) begin
      node_valid_q[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && wr_en) begin
      node_ident_q[wr_idx] <= wr_id;
      node_bw_q[wr_idx]    <= wr_bw;
      node_ov_q[wr_idx]    <= wr_ov;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < llnc_pkg::NUM_TYPES; i++) begin
        type_force_q[i] <= '0;
        type_bw_q[i]    <= '0;
        type_ov_q[i]    <= '0;
      end
    end else if (cmd_i.commit && tw_en) begin
      type_force_q[cur_tidx] <= req_q.force_node;
      type_bw_q[cur_tidx]    <= req_q.bandwidth_weight;
      type_ov_q[cur_tidx]    <= req_q.overload_weight;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

  a_best_any: assert property (@(posedge clk_i) disable iff (!rst_ni)
    best_hit_q |-> any_q)
    else $error("best candidate held with no valid node seen");

  a_match_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    match_hit_q |-> node_valid_q[match_idx_q])
    else $error("matched slot is not valid");

  a_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && wr_en) |=> node_valid_q[$past(wr_idx)])
    else $error("written slot not marked valid");

endmodule

/* hdl/least_loaded_node_chooser.sv */
// ----------------------------------------------------------------------------
// least_loaded_node_chooser
// Worker node table with least-loaded selection and per-type load weights.
// ----------------------------------------------------------------------------
// A request is accepted, then the sequencer scans every slot of the node table
// through its single read port, then commits the table update and loads the
// result register; the commit waits while the previous result is not taken.
// A new request is accepted while the previous result waits.
module least_loaded_node_chooser (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // [15:0] node_id, [19:16] node_type, [35:20] force_node,
  // [51:36] bandwidth_weight, [67:52] overload_weight, [71:68] zero
  input  logic [llnc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] cmd
  input  logic [llnc_pkg::IN_USER_W-1:0]  s_axis_tuser,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [15:0] chosen_node
  output logic [llnc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // [1:0] status, [2] found
  output logic [llnc_pkg::OUT_USER_W-1:0] m_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic                            cfg_we_i,
  input  logic [llnc_pkg::TYPE_W-1:0]     cfg_wdata_i
);

  llnc_pkg::llnc_cmd_t cmd;
  llnc_pkg::llnc_sts_t sts;
  llnc_pkg::llnc_req_t req;
  llnc_pkg::llnc_res_t res;

  assign req.op               = llnc_pkg::llnc_op_e'(s_axis_tuser[1:0]);
  assign req.node_id          = s_axis_tdata[15:0];
  assign req.node_type        = s_axis_tdata[19:16];
  assign req.force_node       = s_axis_tdata[35:20];
  assign req.bandwidth_weight = s_axis_tdata[51:36];
  assign req.overload_weight  = s_axis_tdata[67:52];

  llnc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  llnc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_i       (req),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_o       (res)
  );

  assign m_axis_tdata = res.chosen_node;
  assign m_axis_tuser = {res.found, res.status};

endmodule

/* dv/least_loaded_node_chooser_tb.sv */
// ----------------------------------------------------------------------------
// least_loaded_node_chooser_tb
// Drives add, write and choose requests into the node chooser with random
// source and sink stalls. A behavioural copy of the node table predicts each
// result, which is then checked field by field. Covers the empty table, node
// id zero, forced nodes, the full table, repeated loading of one node and
// several gate type settings.
// ----------------------------------------------------------------------------
module least_loaded_node_chooser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_NODES  = llnc_pkg::MAX_NODES;
  localparam int NUM_TYPES  = llnc_pkg::NUM_TYPES;
  localparam int ID_W       = llnc_pkg::ID_W;
  localparam int TYPE_W     = llnc_pkg::TYPE_W;
  localparam int WGT_W      = llnc_pkg::WGT_W;
  localparam int LOAD_W     = llnc_pkg::LOAD_W;
  localparam int IN_DATA_W  = llnc_pkg::IN_DATA_W;
  localparam int IN_USER_W  = llnc_pkg::IN_USER_W;
  localparam int OUT_DATA_W = llnc_pkg::OUT_DATA_W;
  localparam int OUT_USER_W = llnc_pkg::OUT_USER_W;

  localparam int POOL_SIZE     = MAX_NODES - 1;
  localparam int LOAD_REQUESTS = 40;
  localparam int SETTLE_CYCLES = MAX_NODES + 4;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [IN_USER_W-1:0]  s_axis_tuser;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic                  cfg_we_i;
  logic [TYPE_W-1:0]     cfg_wdata_i;

  // node table and per-type table as the block should hold them
  bit                node_used  [MAX_NODES];
  logic [ID_W-1:0]   node_name  [MAX_NODES];
  logic [LOAD_W-1:0] bw_load    [MAX_NODES];
  logic [LOAD_W-1:0] ov_load    [MAX_NODES];
  logic [ID_W-1:0]   type_force [NUM_TYPES];
  logic [WGT_W-1:0]  type_bw    [NUM_TYPES];
  logic [WGT_W-1:0]  type_ov    [NUM_TYPES];
  logic [TYPE_W-1:0] gate_cfg;

  // ids drawn by the random phases; before the final phase one slot always stays free for id zero
  logic [ID_W-1:0]   id_pool    [POOL_SIZE];

  llnc_pkg::llnc_res_t expected_results[$];
  int                  error_count = 0;
  bit                  idle_on = 1'b1;

  least_loaded_node_chooser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic int find_node(input logic [ID_W-1:0] id);
    for (int i = 0; i < MAX_NODES; i++) begin
      if (node_used[i] && node_name[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic int free_node();
    for (int i = 0; i < MAX_NODES; i++) begin
      if (!node_used[i]) return i;
    end
    return -1;
  endfunction

  function automatic void place_node(input int slot, input logic [ID_W-1:0] id);
    node_used[slot] = 1'b1;
    node_name[slot] = id;
    bw_load[slot]   = '0;
    ov_load[slot]   = '0;
  endfunction

  function automatic logic [LOAD_W-1:0] load_plus(input logic [LOAD_W-1:0] load,
                                                  input logic [WGT_W-1:0]  wgt);
    if (load > {LOAD_W{1'b1}} - LOAD_W'(wgt)) return {LOAD_W{1'b1}};
    return load + LOAD_W'(wgt);
  endfunction

  // expected result of one request; updates the table copy
  function automatic llnc_pkg::llnc_res_t predict_result(
      input llnc_pkg::llnc_op_e op,
      input logic [ID_W-1:0]    nid,
      input logic [TYPE_W-1:0]  ntype,
      input logic [ID_W-1:0]    fnode,
      input logic [WGT_W-1:0]   bw,
      input logic [WGT_W-1:0]   ow);
    llnc_pkg::llnc_res_t res;
    int                  slot;
    bit                  any_node;
    bit                  gate_rank;
    logic [ID_W-1:0]     force_id;
    logic [WGT_W-1:0]    add_bw;
    logic [WGT_W-1:0]    add_ov;
    logic [LOAD_W-1:0]   key_a;
    logic [LOAD_W-1:0]   key_b;
    logic [LOAD_W-1:0]   best_a;
    logic [LOAD_W-1:0]   best_b;
    logic [ID_W-1:0]     best_id;
    res.status      = llnc_pkg::ST_OK;
    res.found       = 1'b0;
    res.chosen_node = '0;
    slot      = -1;
    any_node  = 1'b0;
    gate_rank = (ntype == gate_cfg);
    force_id  = '0;
    add_bw    = '0;
    add_ov    = '0;
    best_a    = '0;
    best_b    = '0;
    best_id   = '0;
    case (op)
      llnc_pkg::CMD_ADD: begin
        if (find_node(nid) >= 0) begin
          res.status = llnc_pkg::ST_DUP;
        end else begin
          slot = free_node();
          if (slot < 0) res.status = llnc_pkg::ST_FULL;
          else place_node(slot, nid);
        end
      end
      llnc_pkg::CMD_WRITE: begin
        if (ntype < NUM_TYPES) begin
          type_force[ntype] = fnode;
          type_bw[ntype]    = bw;
          type_ov[ntype]    = ow;
        end
      end
      llnc_pkg::CMD_CHOOSE: begin
        if (ntype < NUM_TYPES) begin
          force_id = type_force[ntype];
          add_bw   = type_bw[ntype];
          add_ov   = type_ov[ntype];
        end
        foreach (node_used[i]) any_node |= node_used[i];
        if (!any_node) begin
          res.status = llnc_pkg::ST_EMPTY;
        end else if (force_id != '0) begin
          res.found       = 1'b1;
          res.chosen_node = force_id;
          slot = find_node(force_id);
          if (slot < 0) begin
            slot = free_node();
            if (slot < 0) res.status = llnc_pkg::ST_FULL;
            else place_node(slot, force_id);
          end
        end else begin
          for (int i = 0; i < MAX_NODES; i++) begin
            if (node_used[i]) begin
              key_a = gate_rank ? bw_load[i] : ov_load[i];
              key_b = gate_rank ? ov_load[i] : bw_load[i];
              if (slot < 0 || key_a < best_a || (key_a == best_a && key_b < best_b) ||
                  (key_a == best_a && key_b == best_b && node_name[i] < best_id)) begin
                slot    = i;
                best_a  = key_a;
                best_b  = key_b;
                best_id = node_name[i];
              end
            end
          end
          // id zero is never reported and never loaded
          if (slot >= 0 && best_id == '0) begin
            slot = -1;
          end else if (slot >= 0) begin
            res.found       = 1'b1;
            res.chosen_node = best_id;
          end
        end
        if (slot >= 0) begin
          bw_load[slot] = load_plus(bw_load[slot], add_bw);
          ov_load[slot] = load_plus(ov_load[slot], add_ov);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic send_request(input llnc_pkg::llnc_op_e op,
                              input logic [ID_W-1:0]    nid,
                              input logic [TYPE_W-1:0]  ntype,
                              input logic [ID_W-1:0]    fnode,
                              input logic [WGT_W-1:0]   bw,
                              input logic [WGT_W-1:0]   ow);
    int gap;
    gap = idle_on ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {4'b0, ow, bw, fnode, ntype, nid};
    s_axis_tuser  <= op;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    expected_results.push_back(predict_result(op, nid, ntype, fnode, bw, ow));
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_gate_type(input logic [TYPE_W-1:0] value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    gate_cfg    = value;
    @(posedge clk_i);
  endtask

  function automatic logic [ID_W-1:0] pool_id();
    return id_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  function automatic logic [WGT_W-1:0] rand_weight();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      2:       return WGT_W'($urandom_range(0, 7));
      default: return WGT_W'($urandom);
    endcase
  endfunction

  task automatic test_empty_table();
    send_request(llnc_pkg::CMD_CHOOSE, 16'h0000, 4'd0, 16'h0000, 16'h0000, 16'h0000);
    send_request(llnc_pkg::CMD_WRITE, 16'h0000, 4'd5, 16'h8000, 16'hFFFF, 16'h0000);
    // forced node on an empty table still gives no node
    send_request(llnc_pkg::CMD_CHOOSE, 16'h0000, 4'd5, 16'h0000, 16'h0000, 16'h0000);
    send_request(llnc_pkg::CMD_NONE, 16'hFFFF, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(llnc_pkg::CMD_WRITE, 16'h0000, 4'd15, 16'h0000, 16'hFFFF, 16'hFFFF);
  endtask

  task automatic test_add_nodes();
    send_request(llnc_pkg::CMD_ADD, 16'hFFFF, 4'd0, 16'h0000, 16'h0000, 16'h0000);
    send_request(llnc_pkg::CMD_ADD, 16'h0001, 4'd0, 16'h0000, 16'h0000, 16'h0000);
    send_request(llnc_pkg::CMD_ADD, 16'hFFFF, 4'd0, 16'h0000, 16'h0000, 16'h0000);
    send_request(llnc_pkg::CMD_ADD, 16'h8000, 4'd0, 16'h0000, 16'h0000, 16'h0000);
  endtask

  task automatic test_rank_order();
    send_request(llnc_pkg::CMD_WRITE, 16'h0000, 4'd2, 16'h0000, 16'd5, 16'd1);
    send_request(llnc_pkg::CMD_WRITE, 16'h0000, 4'd3, 16'h0000, 16'd1, 16'd5);
    send_request(llnc_pkg::CMD_CHOOSE, 16'h0000, 4'd2, 16'h0000, 16'h0000, 16'h0000);
    send_request(llnc_pkg::CMD_CHOOSE, 16'h0000, 4'd2, 16'h0000, 16'h0000, 16'h0000);
    send_request(llnc_pkg::CMD_CHOOSE, 16'h0000, 4'd3, 16'h0000, 16'h0000, 16'h0000);
    send_request(llnc_pkg::CMD_CHOOSE, 16'h0000, 4'd3, 16'h0000, 16'h0000, 16'h0000);
    write_gate_type(4'd3);
    send_request(llnc_pkg::CMD_CHOOSE, 16'h0000, 4'd3, 16'h0000, 16'h0000, 16'h0000);
    send_request(llnc_pkg::CMD_CHOOSE, 16'h0000, 4'd15, 16'h0000, 16'h0000, 16'h0000);
    // forced node absent: inserted, then found in place
    send_request(llnc_pkg::CMD_WRITE, 16'h0000, 4'd4, 16'h0042, 16'd2, 16'd2);
    send_request(llnc_pkg::CMD_CHOOSE, 16'h0000, 4'd4, 16'h0000, 16'h0000, 16'h0000);
    send_request(llnc_pkg::CMD_CHOOSE, 16'h0000, 4'd4, 16'h0000, 16'h0000, 16'h0000);
  endtask

  task automatic test_forced_load();
    drain_results();
    idle_on = 1'b0;
    send_request(llnc_pkg::CMD_WRITE, 16'h0000, 4'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    for (int n = 0; n < LOAD_REQUESTS; n++) begin
      send_request(llnc_pkg::CMD_CHOOSE, 16'h0000, 4'd7, 16'h0000, 16'h0000, 16'h0000);
    end
    send_request(llnc_pkg::CMD_WRITE, 16'h0000, 4'd7, 16'h0000, rand_weight(),
                 rand_weight());
    drain_results();
    idle_on = 1'b1;
  endtask

  task automatic test_random_phase(input logic [TYPE_W-1:0] gate, input int count,
                                   input bit full_phase);
    int                 pick;
    llnc_pkg::llnc_op_e op;
    logic [ID_W-1:0]    nid;
    logic [TYPE_W-1:0]  ntype;
    logic [ID_W-1:0]    fnode;
    logic [WGT_W-1:0]   bw;
    logic [WGT_W-1:0]   ow;
    write_gate_type(gate);
    for (int n = 0; n < count; n++) begin
      if (n % 64 == 0) idle_on = ($urandom_range(0, 3) != 0);
      pick  = $urandom_range(0, 99);
      nid   = ID_W'($urandom);
      ntype = TYPE_W'($urandom);
      fnode = ID_W'($urandom);
      bw    = WGT_W'($urandom);
      ow    = WGT_W'($urandom);
      if (pick < 15) begin
        op = llnc_pkg::CMD_ADD;
        if (!full_phase || $urandom_range(0, 1) == 0) nid = pool_id();
      end else if (pick < 35) begin
        op = llnc_pkg::CMD_WRITE;
        if ($urandom_range(0, 1) == 0) fnode = '0;
        else if (!full_phase || $urandom_range(0, 2) != 0) fnode = pool_id();
        bw = rand_weight();
        ow = rand_weight();
      end else if (pick < 95) begin
        op = llnc_pkg::CMD_CHOOSE;
      end else begin
        op = llnc_pkg::CMD_NONE;
      end
      send_request(op, nid, ntype, fnode, bw, ow);
    end
    idle_on = 1'b1;
  endtask

  task automatic test_zero_id_and_full();
    drain_results();
    send_request(llnc_pkg::CMD_ADD, 16'h0000, 4'd0, 16'h0000, 16'h0000, 16'h0000);
    send_request(llnc_pkg::CMD_WRITE, 16'h0000, 4'd9, 16'h0000, 16'd7, 16'd7);
    // id zero wins every scan from here on and is never reported
    send_request(llnc_pkg::CMD_CHOOSE, 16'h0000, 4'd9, 16'h0000, 16'h0000, 16'h0000);
    for (int k = 0; k < MAX_NODES; k++) begin
      send_request(llnc_pkg::CMD_ADD, 16'h0100 + ID_W'(k), 4'd0, 16'h0000, 16'h0000,
                   16'h0000);
    end
    send_request(llnc_pkg::CMD_WRITE, 16'h0000, 4'd10, 16'h0110, 16'd3, 16'd3);
    send_request(llnc_pkg::CMD_CHOOSE, 16'h0000, 4'd10, 16'h0000, 16'h0000, 16'h0000);
    send_request(llnc_pkg::CMD_ADD, 16'h0000, 4'd0, 16'h0000, 16'h0000, 16'h0000);
  endtask

  always @(posedge clk_i) begin : result_check
    llnc_pkg::llnc_res_t want;
    if (rst_ni === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result user %0h data %0h",
                                  m_axis_tuser, m_axis_tdata));
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tuser[1:0] !== want.status) begin
          report_mismatch($sformatf("status %0d, expected %0d",
                                    m_axis_tuser[1:0], want.status));
        end
        if (m_axis_tuser[2] !== want.found) begin
          report_mismatch($sformatf("found %0b, expected %0b", m_axis_tuser[2], want.found));
        end
        if (m_axis_tdata !== want.chosen_node) begin
          report_mismatch($sformatf("chosen node %0h, expected %0h",
                                    m_axis_tdata, want.chosen_node));
        end
      end
    end
  end

  initial begin : result_sink
    int stall;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = idle_on ? $urandom_range(0, 18) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid !== 1'b1);
    end
  end

  initial begin
    #50ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic [ID_W-1:0] cand;
    bit              clash;
    rst_ni        = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    s_axis_tvalid = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    gate_cfg      = '0;
    foreach (node_used[i]) begin
      node_used[i] = 1'b0;
      node_name[i] = '0;
      bw_load[i]   = '0;
      ov_load[i]   = '0;
    end
    foreach (type_force[i]) begin
      type_force[i] = '0;
      type_bw[i]    = '0;
      type_ov[i]    = '0;
    end
    id_pool[0] = 16'hFFFF;
    id_pool[1] = 16'h0001;
    id_pool[2] = 16'h8000;
    id_pool[3] = 16'h0042;
    for (int k = 4; k < POOL_SIZE; k++) begin
      do begin
        cand  = ID_W'($urandom);
        clash = (cand == '0);
        for (int j = 0; j < k; j++) begin
          if (id_pool[j] == cand) clash = 1'b1;
        end
      end while (clash);
      id_pool[k] = cand;
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_add_nodes();
    test_rank_order();
    test_random_phase(TYPE_W'($urandom), 320, 1'b0);
    test_forced_load();
    test_random_phase(4'd0, 320, 1'b0);
    test_random_phase(4'd15, 270, 1'b0);
    test_zero_id_and_full();
    test_random_phase(TYPE_W'($urandom), 150, 1'b1);

    drain_results();
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
